// ----- rtl/tfr_pkg.sv -----
// package for the text frame receiver
// holds buffer sizing, field widths, beat kinds and register indexes
// no dependencies
package tfr_pkg;

    localparam int DEPTH    = 128;
    localparam int CNT_W    = $clog2(DEPTH);
    localparam int ADDR_W   = CNT_W + 1;
    localparam int STORE_N  = 2 * DEPTH;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 7;
    localparam int LEN_W    = 7;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'd36;
    localparam logic [BYTE_W-1:0] TAIL_RESET = 8'd13;
    localparam logic [BYTE_W-1:0] SKIP_RESET = 8'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_RX      = 2'd0,
        KIND_READ    = 2'd1,
        KIND_RELEASE = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD = 2'd0,
        CFG_TAIL = 2'd1,
        CFG_SKIP = 2'd2
    } cfg_idx_t;

endpackage

// ----- rtl/tfr_ram.sv -----
// generic single write port ram with registered read and read enable
// no dependencies
module tfr_ram #(
    parameter int DATA_W = 8,
    parameter int RAM_DEPTH = 256
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [$clog2(RAM_DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]            wdata,
    input  logic                         re,
    input  logic [$clog2(RAM_DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]            rdata
);

    logic [DATA_W-1:0] mem [RAM_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/text_frame_receiver_unit.sv -----
// text frame receiver top level: deframer state, frame store and result pipeline
// depends on tfr_pkg and tfr_ram
//
// usage: each input beat carries a kind (received byte, character read or frame
// release), the received byte and a character position. every input beat yields
// exactly one result beat: ready flag and length of the published frame as they
// stood before the beat, the character read, and done, dropped and overflow flags
// for received bytes. head, tail and skip bytes are set through the write port
// (cfg_we, cfg_index, cfg_wdata); index 3 is ignored. the user must write them
// only while the block is idle; the block itself does not enforce this. the frame
// store read and the flags are registered in the read stage, then in the output
// register. throughput: one beat per cycle unless stalled; the frame store has one
// write and one read port, every beat reads and only received bytes may write.
// reset: frame state, ready flag and registers return to their defaults, all beats
// in flight are dropped; the frame store is not cleared, only written positions
// of a published frame are ever put out as characters.
// stall: when m_ready is low the output register holds and one more beat is
// absorbed in the read stage; after that s_ready falls until results drain.
module text_frame_receiver_unit
    import tfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [KIND_W-1:0]    s_kind,
    input  logic [BYTE_W-1:0]    s_rx_byte,
    input  logic [POS_W-1:0]     s_position,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_ready_res,
    output logic [BYTE_W-1:0]    m_frame_char,
    output logic [LEN_W-1:0]     m_ready_length,
    output logic                 m_frame_done,
    output logic                 m_frame_dropped,
    output logic                 m_overflowed
);

    typedef struct packed {
        logic             ready_res;
        logic [LEN_W-1:0] length;
        logic             done;
        logic             dropped;
        logic             ovf;
        logic             char_sel;
    } res_t;

    logic [BYTE_W-1:0] head_reg;
    logic [BYTE_W-1:0] tail_reg;
    logic [BYTE_W-1:0] skip_reg;

    logic              in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  zero_pos_reg, zero_pos_next;
    logic              bank_reg, bank_next;
    logic              rvalid_reg, rvalid_next;
    logic [CNT_W-1:0]  rlen_reg, rlen_next;

    logic              s1_valid_reg;
    res_t              s1_reg, s1_next;

    logic              m_valid_reg;
    res_t              m_reg;
    logic [BYTE_W-1:0] m_char_reg;

    logic              accept;
    logic              s1_advance;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    assign s1_advance = !m_valid_reg || m_ready;
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign accept     = s_valid && s_ready;

    assign wr_addr = {!bank_reg, fill_reg};
    assign rd_addr = {bank_reg, CNT_W'(s_position)};

    always_comb begin
        in_frame_next = in_frame_reg;
        fill_next     = fill_reg;
        zero_pos_next = zero_pos_reg;
        bank_next     = bank_reg;
        rvalid_next   = rvalid_reg;
        rlen_next     = rlen_reg;
        wr_en         = 1'b0;

        s1_next.ready_res = rvalid_reg;
        s1_next.length    = rvalid_reg ? LEN_W'(rlen_reg) : '0;
        s1_next.done      = 1'b0;
        s1_next.dropped   = 1'b0;
        s1_next.ovf       = 1'b0;
        s1_next.char_sel  = 1'b0;

        if (accept) begin
            unique case (kind_t'(s_kind))
                KIND_RX: begin
                    priority if (s_rx_byte == head_reg) begin
                        in_frame_next = 1'b1;
                        fill_next     = '0;
                        zero_pos_next = '0;
                    end else if (in_frame_reg) begin
                        priority if (s_rx_byte == tail_reg) begin
                            if (!rvalid_reg) begin
                                bank_next    = !bank_reg;
                                rlen_next    = zero_pos_reg;
                                rvalid_next  = 1'b1;
                                s1_next.done = 1'b1;
                            end else begin
                                s1_next.dropped = 1'b1;
                            end
                            in_frame_next = 1'b0;
                            fill_next     = '0;
                            zero_pos_next = '0;
                        end else if (s_rx_byte != skip_reg) begin
                            if (fill_reg < CNT_W'(DEPTH - 1)) begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + 1'b1;
                                if (zero_pos_reg == fill_reg && s_rx_byte != '0) begin
                                    zero_pos_next = zero_pos_reg + 1'b1;
                                end
                            end else begin
                                in_frame_next = 1'b0;
                                fill_next     = '0;
                                zero_pos_next = '0;
                                s1_next.ovf   = 1'b1;
                            end
                        end else begin
                        end
                    end else begin
                    end
                end
                KIND_READ: begin
                    s1_next.char_sel = rvalid_reg && (32'(s_position) < 32'(rlen_reg));
                end
                KIND_RELEASE: begin
                    rvalid_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    tfr_ram #(
        .DATA_W    (BYTE_W),
        .RAM_DEPTH (STORE_N)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (s_rx_byte),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= HEAD_RESET;
            tail_reg     <= TAIL_RESET;
            skip_reg     <= SKIP_RESET;
            in_frame_reg <= 1'b0;
            fill_reg     <= '0;
            zero_pos_reg <= '0;
            bank_reg     <= 1'b0;
            rvalid_reg   <= 1'b0;
            rlen_reg     <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_HEAD: head_reg <= cfg_wdata;
                    CFG_TAIL: tail_reg <= cfg_wdata;
                    CFG_SKIP: skip_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            in_frame_reg <= in_frame_next;
            fill_reg     <= fill_next;
            zero_pos_reg <= zero_pos_next;
            bank_reg     <= bank_next;
            rvalid_reg   <= rvalid_next;
            rlen_reg     <= rlen_next;
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_advance) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
        if (s1_advance && s1_valid_reg) begin
            m_reg      <= s1_reg;
            m_char_reg <= s1_reg.char_sel ? rd_data : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ready_res     = m_reg.ready_res;
    assign m_frame_char    = m_char_reg;
    assign m_ready_length  = m_reg.length;
    assign m_frame_done    = m_reg.done;
    assign m_frame_dropped = m_reg.dropped;
    assign m_overflowed    = m_reg.ovf;

endmodule

// ----- rtl/tfr_checker.sv -----
// port level checks for the text frame receiver, bound to the top level
// depends on tfr_pkg and text_frame_receiver_unit
module tfr_checker
    import tfr_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_ready_res,
    input logic [BYTE_W-1:0] m_frame_char,
    input logic [LEN_W-1:0]  m_ready_length,
    input logic              m_frame_done,
    input logic              m_frame_dropped,
    input logic              m_overflowed
);

    // a frame is published only when nothing was pending
    a_done_needs_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> !m_ready_res)
        else $error("frame published over a pending frame");

    // a frame is dropped only when something was pending
    a_drop_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_dropped) |-> m_ready_res)
        else $error("frame dropped with no frame pending");

    // a byte has at most one outcome
    a_one_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($countones({m_frame_done, m_frame_dropped, m_overflowed}) <= 1))
        else $error("more than one frame outcome in one beat");

    // nothing pending reads as empty
    a_empty_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready_res) |-> (m_ready_length == '0 && m_frame_char == '0))
        else $error("nonzero length or character with no frame pending");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_frame_char)
            && $stable(m_ready_length)))
        else $error("result beat changed while stalled");

endmodule

bind text_frame_receiver_unit tfr_checker u_tfr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_ready_res     (m_ready_res),
    .m_frame_char    (m_frame_char),
    .m_ready_length  (m_ready_length),
    .m_frame_done    (m_frame_done),
    .m_frame_dropped (m_frame_dropped),
    .m_overflowed    (m_overflowed)
);
